// ===== rtl/ert_pkg.sv =====
package ert_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    FN_STORE = 2'd0,
    FN_POST  = 2'd1,
    FN_GET   = 2'd2,
    FN_CHECK = 2'd3
  } ert_func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_APPLY,
    ST_AGE,
    ST_AGE_DRAIN,
    ST_DONE
  } ert_state_t;

  // fixed part of one table entry, the insertion rank sits above it in memory
  typedef struct packed {
    logic [15:0] number;
    logic [7:0]  etype;
    logic        signaled;
    logic [31:0] value;
  } ert_rec_t;

endpackage

// ===== rtl/ert_req_if.sv =====
interface ert_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] requestor;
  logic [7:0]  event_type;
  logic [15:0] thread_number;
  logic [31:0] event_data;

  modport source (
    output valid, func, requestor, event_type, thread_number, event_data,
    input  ready
  );

  modport sink (
    input  valid, func, requestor, event_type, thread_number, event_data,
    output ready
  );
endinterface

// ===== rtl/ert_rsp_if.sv =====
interface ert_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] event_id;
  logic [31:0] event_value;
  logic        table_full;

  modport source (
    output valid, found, event_id, event_value, table_full,
    input  ready
  );

  modport sink (
    input  valid, found, event_id, event_value, table_full,
    output ready
  );
endinterface

// ===== rtl/ert_mem.sv =====
module ert_mem #(
  parameter int unsigned DEPTH = ert_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned WIDTH = 61
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== rtl/event_request_table.sv =====
// Table of pending event requests. Each item is handled on its own: the
// controller sweeps the entry memory one address per cycle to find the free
// slot, the fill level and the oldest matching entry, then writes the result
// back. A store, post, check or get that finds nothing passes through the
// scan, drain, apply and done states; a get that removes an entry runs a
// second sweep of the memory to close the gap in the insertion order,
// followed by its drain step. The result sits in an output register,
// so the next item is accepted while it waits to be taken.
module event_request_table #(
  parameter int unsigned TABLE_DEPTH = ert_pkg::TABLE_DEPTH_DEF
) (
  input logic  clk,
  input logic  rst,
  ert_req_if.sink   req,
  ert_rsp_if.source rsp
);
  import ert_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned RW = $bits(ert_rec_t);
  localparam int unsigned MW = AW + RW;
  localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);

  ert_state_t state, state_next;

  logic [TABLE_DEPTH-1:0] valid;
  logic [AW-1:0]          cnt;

  logic [1:0]  op_func;
  logic [15:0] op_requestor;
  logic [7:0]  op_type;
  logic [15:0] op_tnum;
  logic [31:0] op_data;

  logic          pipe_valid;
  logic          pipe_aging;
  logic          pipe_ent_valid;
  logic [AW-1:0] pipe_idx;

  logic [CW-1:0] count;
  logic          slot_found;
  logic [AW-1:0] slot;
  logic          best_found;
  logic [AW-1:0] best_idx;
  logic [AW-1:0] best_age;
  ert_rec_t      best_rec;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [MW-1:0] mem_rdata;

  logic [AW-1:0] rd_age;
  ert_rec_t      rd_rec;
  logic          hit;
  logic          better;

  logic        req_ready;
  logic        accept;
  logic        rsp_load;
  logic        rsp_valid;
  logic        res_found;
  logic [15:0] res_number;
  logic [31:0] res_value;
  logic        res_full;

  ert_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (MW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign accept    = req.valid && req_ready;
  assign req.ready = req_ready;

  assign rd_age = mem_rdata[MW-1:RW];
  assign rd_rec = ert_rec_t'(mem_rdata[RW-1:0]);

  always_comb begin
    if (op_func == FN_POST) begin
      hit = ((op_tnum == 16'd0) || (rd_rec.number == op_tnum)) && (rd_rec.etype == op_type);
    end else begin
      hit = rd_rec.signaled;
    end
    better = pipe_ent_valid && hit && (!best_found || (rd_age < best_age));
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt == LAST) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_APPLY;
      ST_APPLY: begin
        if ((op_func == FN_GET) && best_found) state_next = ST_AGE;
        else state_next = ST_DONE;
      end
      ST_AGE: begin
        if (cnt == LAST) state_next = ST_AGE_DRAIN;
      end
      ST_AGE_DRAIN: state_next = ST_DONE;
      ST_DONE: begin
        if (!rsp_valid || rsp.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_ready = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = cnt;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    rsp_load  = 1'b0;
    case (state)
      ST_IDLE: req_ready = 1'b1;
      ST_SCAN: mem_re = 1'b1;
      ST_AGE:  mem_re = 1'b1;
      ST_APPLY: begin
        if ((op_func == FN_STORE) && slot_found) begin
          mem_we    = 1'b1;
          mem_waddr = slot;
          mem_wdata = {count[AW-1:0], op_requestor + 16'd1, op_type, 1'b0, 32'd0};
        end else if ((op_func == FN_POST) && best_found) begin
          mem_we    = 1'b1;
          mem_waddr = best_idx;
          mem_wdata = {best_age, best_rec.number, best_rec.etype, 1'b1, op_data};
        end
      end
      ST_DONE: rsp_load = !rsp_valid || rsp.ready;
      default: ;
    endcase
    // close the gap left by a removed entry
    if (pipe_valid && pipe_aging && pipe_ent_valid && (rd_age > best_age)) begin
      mem_we    = 1'b1;
      mem_waddr = pipe_idx;
      mem_wdata = {rd_age - AW'(1), rd_rec};
    end
  end

  always_comb begin
    res_found  = 1'b0;
    res_number = '0;
    res_value  = '0;
    res_full   = 1'b0;
    case (op_func)
      FN_STORE: begin
        res_found  = slot_found;
        res_number = slot_found ? op_requestor + 16'd1 : 16'd0;
        res_full   = !slot_found;
      end
      FN_POST: ;
      default: begin
        res_found  = best_found;
        res_number = best_found ? best_rec.number : 16'd0;
        res_value  = best_found ? best_rec.value : 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      pipe_valid <= 1'b0;
      pipe_aging <= 1'b0;
      valid      <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      pipe_valid <= (state == ST_SCAN) || (state == ST_AGE);
      pipe_aging <= (state == ST_AGE);
      if ((state == ST_SCAN) || (state == ST_AGE)) begin
        cnt <= (cnt == LAST) ? '0 : cnt + AW'(1);
      end
      if (state == ST_APPLY) begin
        if ((op_func == FN_STORE) && slot_found) valid[slot] <= 1'b1;
        if ((op_func == FN_GET) && best_found) valid[best_idx] <= 1'b0;
      end
      if (rsp_load) rsp_valid <= 1'b1;
      else if (rsp.ready) rsp_valid <= 1'b0;
    end
  end

  // item capture, sweep pipeline and accumulators
  always_ff @(posedge clk) begin
    pipe_idx       <= cnt;
    pipe_ent_valid <= valid[cnt];
    if (accept) begin
      op_func      <= req.func;
      op_requestor <= req.requestor;
      op_type      <= req.event_type;
      op_tnum      <= req.thread_number;
      op_data      <= req.event_data;
      count        <= '0;
      slot_found   <= 1'b0;
      best_found   <= 1'b0;
    end else if (pipe_valid && !pipe_aging) begin
      if (pipe_ent_valid) begin
        count <= count + CW'(1);
      end else if (!slot_found) begin
        slot_found <= 1'b1;
        slot       <= pipe_idx;
      end
      if (better) begin
        best_found <= 1'b1;
        best_idx   <= pipe_idx;
        best_age   <= rd_age;
        best_rec   <= rd_rec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.found       <= res_found;
      rsp.event_id    <= res_number;
      rsp.event_value <= res_value;
      rsp.table_full  <= res_full;
    end
  end

  assign rsp.valid = rsp_valid;
endmodule

// ===== rtl/ert_checker.sv =====
module ert_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        rsp_found,
  input logic [15:0] rsp_event_id,
  input logic [31:0] rsp_event_value,
  input logic        rsp_table_full
);

  // one item at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("item accepted while another is in work");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_id))
    else $error("stalled result changed");

  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_table_full |-> !rsp_found && (rsp_event_id == 16'd0))
    else $error("refused store reports an entry");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_found |-> (rsp_event_value == 32'd0))
    else $error("result without hit carries a value");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid straight after reset");

endmodule

bind event_request_table ert_checker u_ert_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_found       (rsp.found),
  .rsp_event_id    (rsp.event_id),
  .rsp_event_value (rsp.event_value),
  .rsp_table_full  (rsp.table_full)
);
